// ===== hw/rtl/ec_scalar_multiply_mod_top_macros.svh =====
// Assertion macros for the controller (ecsm_ctrl.sv) of the scalar multiplier.
`ifndef EC_SCALAR_MULTIPLY_MOD_TOP_MACROS_SVH
`define EC_SCALAR_MULTIPLY_MOD_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ECSM_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ecsm assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ECSM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ecsm assertion failed");

`endif

// ===== hw/rtl/ecsm_pkg.sv =====
package ecsm_pkg;

  localparam int W = 64;
  localparam int CNT_W = $clog2(W);
  localparam int SLOTS = 16;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int IDX_W = 1;

  localparam logic [IDX_W-1:0] REG_MODULUS = 1'd0;
  localparam logic [IDX_W-1:0] REG_CURVE_A = 1'd1;

  typedef enum logic [1:0] {
    KIND_AFFINE,
    KIND_INF,
    KIND_FAIL
  } kind_t;

  typedef enum logic [SLOT_W-1:0] {
    S_PX, S_PY, S_RX, S_RY, S_AS, S_NUM, S_DEN, S_LAM,
    S_Z, S_R0, S_R1, S_T0, S_T1, S_TMP, S_ZS, S_OS
  } slot_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LD, OP_MOV, OP_ADD, OP_SUB, OP_MUL, OP_MULQ,
    OP_DIV, OP_MODM, OP_CMP, OP_SHK, OP_CAPX, OP_CAPY, OP_CAPD
  } op_t;

  typedef enum logic [2:0] {
    SRC_X, SRC_Y, SRC_A, SRC_M, SRC_ZERO, SRC_ONE
  } src_t;

  typedef struct packed {
    op_t   op;
    slot_t ra;
    slot_t rb;
    slot_t rd;
    src_t  src;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic eq;
    logic kbit0;
    logic kzero;
  } dp_status_t;

  function automatic logic [W-1:0] add_mod(input logic [W-1:0] a, input logic [W-1:0] b,
                                           input logic [W-1:0] m);
    logic [W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, m}) s = s - {1'b0, m};
    return s[W-1:0];
  endfunction

  function automatic logic [W-1:0] sub_mod(input logic [W-1:0] a, input logic [W-1:0] b,
                                           input logic [W-1:0] m);
    return (a >= b) ? (a - b) : (a + (m - b));
  endfunction

endpackage

// ===== hw/rtl/ecsm_ram.sv =====
module ecsm_ram #(
  parameter int DATA_W = 64,
  parameter int DEPTH  = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [DATA_W-1:0]        rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [DATA_W-1:0]        rdata_b
);
  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end
endmodule

// ===== hw/rtl/ecsm_dp.sv =====
module ecsm_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [ecsm_pkg::W-1:0] in_scalar,
  input  logic [ecsm_pkg::W-1:0] in_x,
  input  logic [ecsm_pkg::W-1:0] in_y,
  input  logic [ecsm_pkg::W-1:0] mod_eff,
  input  logic [ecsm_pkg::W-1:0] curve_a,
  input  logic                 cmd_valid,
  input  ecsm_pkg::cmd_t       cmd,
  output ecsm_pkg::dp_status_t st,
  output logic [ecsm_pkg::W-1:0] res_x,
  output logic [ecsm_pkg::W-1:0] res_y,
  output logic [ecsm_pkg::W-1:0] res_den
);
  import ecsm_pkg::*;

  typedef enum logic [1:0] {D_IDLE, D_EXEC, D_MUL, D_DIV} dstate_t;

  dstate_t          dstate;
  cmd_t             cur;
  logic [W-1:0]     kreg, x_in, y_in;
  logic [W-1:0]     acc, mx, my, quo, rem, dvs, qreg;
  logic             ph;
  logic [CNT_W-1:0] cnt;
  logic             we, done, eq;
  slot_t            waddr;
  logic [W-1:0]     wdata;
  logic [W-1:0]     opa, opb, ld_val, mul_dbl, mul_step, rem_next, quo_next;
  logic [W:0]       shifted, diff;
  logic             ge;

  ecsm_ram #(.DATA_W(W), .DEPTH(SLOTS)) u_regs (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (cmd.ra),
    .rdata_a (opa),
    .raddr_b (cmd.rb),
    .rdata_b (opb)
  );

  always_comb begin
    case (cur.src)
      SRC_X:    ld_val = x_in;
      SRC_Y:    ld_val = y_in;
      SRC_A:    ld_val = curve_a;
      SRC_M:    ld_val = mod_eff;
      SRC_ONE:  ld_val = W'(1);
      default:  ld_val = '0;
    endcase
    mul_dbl  = add_mod(acc, acc, mod_eff);
    mul_step = my[W-1] ? add_mod(acc, mx, mod_eff) : acc;
    shifted  = {rem, quo[W-1]};
    diff     = shifted - {1'b0, dvs};
    ge       = (shifted >= {1'b0, dvs});
    rem_next = ge ? diff[W-1:0] : shifted[W-1:0];
    quo_next = {quo[W-2:0], ge};
  end

  assign st.done  = done;
  assign st.eq    = eq;
  assign st.kbit0 = kreg[0];
  assign st.kzero = (kreg == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      dstate <= D_IDLE;
      we     <= 1'b0;
      done   <= 1'b0;
    end else begin
      we   <= 1'b0;
      done <= 1'b0;
      if (start) begin
        kreg <= in_scalar;
        x_in <= in_x;
        y_in <= in_y;
      end
      case (dstate)
        D_IDLE: begin
          if (cmd_valid) begin
            cur    <= cmd;
            dstate <= D_EXEC;
          end
        end
        D_EXEC: begin
          dstate <= D_IDLE;
          waddr  <= cur.rd;
          case (cur.op)
            OP_LD: begin
              we    <= 1'b1;
              wdata <= ld_val;
              done  <= 1'b1;
            end
            OP_MOV: begin
              we    <= 1'b1;
              wdata <= opa;
              done  <= 1'b1;
            end
            OP_ADD: begin
              we    <= 1'b1;
              wdata <= add_mod(opa, opb, mod_eff);
              done  <= 1'b1;
            end
            OP_SUB: begin
              we    <= 1'b1;
              wdata <= sub_mod(opa, opb, mod_eff);
              done  <= 1'b1;
            end
            OP_CMP: begin
              eq   <= (opa == opb);
              done <= 1'b1;
            end
            OP_SHK: begin
              kreg <= kreg >> 1;
              done <= 1'b1;
            end
            OP_CAPX: begin
              res_x <= opa;
              done  <= 1'b1;
            end
            OP_CAPY: begin
              res_y <= opa;
              done  <= 1'b1;
            end
            OP_CAPD: begin
              res_den <= opa;
              done    <= 1'b1;
            end
            OP_MUL, OP_MULQ: begin
              acc    <= '0;
              mx     <= (cur.op == OP_MULQ) ? qreg : opa;
              my     <= (cur.op == OP_MULQ) ? opa : opb;
              ph     <= 1'b0;
              cnt    <= CNT_W'(W - 1);
              dstate <= D_MUL;
            end
            OP_DIV, OP_MODM: begin
              quo    <= opa;
              rem    <= '0;
              dvs    <= (cur.op == OP_MODM) ? mod_eff : opb;
              cnt    <= CNT_W'(W - 1);
              dstate <= D_DIV;
            end
            default: done <= 1'b1;
          endcase
        end
        D_MUL: begin
          if (!ph) begin
            acc <= mul_dbl;
            ph  <= 1'b1;
          end else begin
            acc <= mul_step;
            my  <= my << 1;
            ph  <= 1'b0;
            if (cnt == '0) begin
              we     <= 1'b1;
              waddr  <= cur.rd;
              wdata  <= mul_step;
              done   <= 1'b1;
              dstate <= D_IDLE;
            end else begin
              cnt <= cnt - 1'b1;
            end
          end
        end
        D_DIV: begin
          rem <= rem_next;
          quo <= quo_next;
          if (cnt == '0) begin
            we    <= 1'b1;
            waddr <= cur.rd;
            wdata <= rem_next;
            if (cur.op == OP_DIV) qreg <= quo_next;
            done   <= 1'b1;
            dstate <= D_IDLE;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        default: dstate <= D_IDLE;
      endcase
    end
  end
endmodule

// ===== hw/rtl/ecsm_ctrl.sv =====
`include "ec_scalar_multiply_mod_top_macros.svh"

module ecsm_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 in_inf,
  output logic                 idle,
  input  logic                 out_ready,
  output logic                 out_valid,
  output ecsm_pkg::kind_t      kind,
  output logic                 cmd_valid,
  output ecsm_pkg::cmd_t       cmd,
  input  ecsm_pkg::dp_status_t st
);
  import ecsm_pkg::*;

  typedef enum logic [5:0] {
    C_IDLE, C_LX, C_MX, C_LY, C_MY, C_LA, C_MA, C_L0, C_L1,
    C_TOP, C_SHIFT, C_PEND,
    C_PSTART, C_CPX, C_CPY, C_CMPX, C_SUMY, C_ZY,
    C_SQ, C_N1, C_N2, C_N3, C_DD, C_NUMS, C_DENS,
    C_IR0, C_IR1, C_IT0, C_IT1, C_ITST, C_IDIV, C_IMR0, C_IMR1,
    C_IMQ, C_IST, C_IMT0, C_IMT1, C_IGCD,
    C_LAM, C_L2, C_X1, C_X2, C_Y1, C_Y2, C_Y3, C_WX, C_WY,
    C_FWAIT, C_CX, C_CY, C_CD
  } cstate_t;

  cstate_t state, nxt;
  cmd_t    cmd_c;
  logic    pend, p_inf, r_inf, fail, dbl;
  logic    set_dinf, clr_dinf, set_fail, set_dbl, clr_dbl, publish, adv;
  slot_t   qx, qy;

  function automatic cmd_t mk(input op_t op, input slot_t ra, input slot_t rb,
                              input slot_t rd);
    cmd_t c;
    c.op  = op;
    c.ra  = ra;
    c.rb  = rb;
    c.rd  = rd;
    c.src = SRC_ZERO;
    return c;
  endfunction

  function automatic cmd_t mkld(input src_t src, input slot_t rd);
    cmd_t c;
    c     = mk(OP_LD, S_ZS, S_ZS, rd);
    c.src = src;
    return c;
  endfunction

  assign qx   = dbl ? S_PX : S_RX;
  assign qy   = dbl ? S_PY : S_RY;
  assign idle = (state == C_IDLE);

  always_comb begin
    cmd_c    = mk(OP_NONE, S_ZS, S_ZS, S_TMP);
    nxt      = state;
    set_dinf = 1'b0;
    clr_dinf = 1'b0;
    set_fail = 1'b0;
    set_dbl  = 1'b0;
    clr_dbl  = 1'b0;
    publish  = 1'b0;
    case (state)
      C_IDLE:   if (start) nxt = C_LX;
      C_LX:     begin cmd_c = mkld(SRC_X, S_PX); nxt = C_MX; end
      C_MX:     begin cmd_c = mk(OP_MODM, S_PX, S_ZS, S_PX); nxt = C_LY; end
      C_LY:     begin cmd_c = mkld(SRC_Y, S_PY); nxt = C_MY; end
      C_MY:     begin cmd_c = mk(OP_MODM, S_PY, S_ZS, S_PY); nxt = C_LA; end
      C_LA:     begin cmd_c = mkld(SRC_A, S_AS); nxt = C_MA; end
      C_MA:     begin cmd_c = mk(OP_MODM, S_AS, S_ZS, S_AS); nxt = C_L0; end
      C_L0:     begin cmd_c = mkld(SRC_ZERO, S_ZS); nxt = C_L1; end
      C_L1:     begin cmd_c = mkld(SRC_ONE, S_OS); nxt = C_TOP; end
      C_TOP: begin
        if (st.kzero) begin
          nxt = C_FWAIT;
        end else if (st.kbit0) begin
          clr_dbl = 1'b1;
          nxt     = C_PSTART;
        end else begin
          nxt = C_SHIFT;
        end
      end
      C_SHIFT: begin
        cmd_c = mk(OP_SHK, S_ZS, S_ZS, S_TMP);
        if (st.kzero) begin
          nxt = C_FWAIT;
        end else begin
          set_dbl = 1'b1;
          nxt     = C_PSTART;
        end
      end
      C_PEND: begin
        if (fail) nxt = C_FWAIT;
        else if (dbl) nxt = C_TOP;
        else nxt = C_SHIFT;
      end
      C_PSTART: begin
        if (dbl ? p_inf : p_inf) nxt = C_PEND;
        else if (!dbl && r_inf) nxt = C_CPX;
        else nxt = C_CMPX;
      end
      C_CPX:  begin cmd_c = mk(OP_MOV, S_PX, S_ZS, S_RX); nxt = C_CPY; end
      C_CPY: begin
        cmd_c    = mk(OP_MOV, S_PY, S_ZS, S_RY);
        clr_dinf = 1'b1;
        nxt      = C_PEND;
      end
      C_CMPX: begin
        cmd_c = mk(OP_CMP, S_PX, qx, S_TMP);
        nxt   = st.eq ? C_SUMY : C_NUMS;
      end
      C_SUMY: begin cmd_c = mk(OP_ADD, S_PY, qy, S_TMP); nxt = C_ZY; end
      C_ZY: begin
        cmd_c = mk(OP_CMP, S_TMP, S_ZS, S_TMP);
        if (st.eq) begin
          set_dinf = 1'b1;
          nxt      = C_PEND;
        end else begin
          nxt = C_SQ;
        end
      end
      C_SQ:   begin cmd_c = mk(OP_MUL, S_PX, S_PX, S_Z); nxt = C_N1; end
      C_N1:   begin cmd_c = mk(OP_ADD, S_Z, S_Z, S_NUM); nxt = C_N2; end
      C_N2:   begin cmd_c = mk(OP_ADD, S_NUM, S_Z, S_NUM); nxt = C_N3; end
      C_N3:   begin cmd_c = mk(OP_ADD, S_NUM, S_AS, S_NUM); nxt = C_DD; end
      C_DD:   begin cmd_c = mk(OP_ADD, S_PY, S_PY, S_DEN); nxt = C_IR0; end
      C_NUMS: begin cmd_c = mk(OP_SUB, qy, S_PY, S_NUM); nxt = C_DENS; end
      C_DENS: begin cmd_c = mk(OP_SUB, qx, S_PX, S_DEN); nxt = C_IR0; end
      C_IR0:  begin cmd_c = mkld(SRC_M, S_R0); nxt = C_IR1; end
      C_IR1:  begin cmd_c = mk(OP_MOV, S_DEN, S_ZS, S_R1); nxt = C_IT0; end
      C_IT0:  begin cmd_c = mk(OP_MOV, S_ZS, S_ZS, S_T0); nxt = C_IT1; end
      C_IT1:  begin cmd_c = mk(OP_MOV, S_OS, S_ZS, S_T1); nxt = C_ITST; end
      C_ITST: begin
        cmd_c = mk(OP_CMP, S_R1, S_ZS, S_TMP);
        nxt   = st.eq ? C_IGCD : C_IDIV;
      end
      C_IDIV: begin cmd_c = mk(OP_DIV, S_R0, S_R1, S_TMP); nxt = C_IMR0; end
      C_IMR0: begin cmd_c = mk(OP_MOV, S_R1, S_ZS, S_R0); nxt = C_IMR1; end
      C_IMR1: begin cmd_c = mk(OP_MOV, S_TMP, S_ZS, S_R1); nxt = C_IMQ; end
      C_IMQ:  begin cmd_c = mk(OP_MULQ, S_T1, S_ZS, S_TMP); nxt = C_IST; end
      C_IST:  begin cmd_c = mk(OP_SUB, S_T0, S_TMP, S_TMP); nxt = C_IMT0; end
      C_IMT0: begin cmd_c = mk(OP_MOV, S_T1, S_ZS, S_T0); nxt = C_IMT1; end
      C_IMT1: begin cmd_c = mk(OP_MOV, S_TMP, S_ZS, S_T1); nxt = C_ITST; end
      C_IGCD: begin
        cmd_c = mk(OP_CMP, S_R0, S_OS, S_TMP);
        if (st.eq) begin
          nxt = C_LAM;
        end else begin
          set_fail = 1'b1;
          nxt      = C_PEND;
        end
      end
      C_LAM:  begin cmd_c = mk(OP_MUL, S_NUM, S_T0, S_LAM); nxt = C_L2; end
      C_L2:   begin cmd_c = mk(OP_MUL, S_LAM, S_LAM, S_Z); nxt = C_X1; end
      C_X1:   begin cmd_c = mk(OP_SUB, S_Z, S_PX, S_Z); nxt = C_X2; end
      C_X2:   begin cmd_c = mk(OP_SUB, S_Z, qx, S_Z); nxt = C_Y1; end
      C_Y1:   begin cmd_c = mk(OP_SUB, S_PX, S_Z, S_TMP); nxt = C_Y2; end
      C_Y2:   begin cmd_c = mk(OP_MUL, S_LAM, S_TMP, S_TMP); nxt = C_Y3; end
      C_Y3:   begin cmd_c = mk(OP_SUB, S_TMP, S_PY, S_TMP); nxt = C_WX; end
      C_WX:   begin cmd_c = mk(OP_MOV, S_Z, S_ZS, qx); nxt = C_WY; end
      C_WY: begin
        cmd_c    = mk(OP_MOV, S_TMP, S_ZS, qy);
        clr_dinf = 1'b1;
        nxt      = C_PEND;
      end
      C_FWAIT: if (!out_valid) nxt = C_CX;
      C_CX: begin
        cmd_c = mk(OP_CAPX, (fail || r_inf) ? S_ZS : S_RX, S_ZS, S_TMP);
        nxt   = C_CY;
      end
      C_CY: begin
        cmd_c = mk(OP_CAPY, fail ? S_ZS : (r_inf ? S_OS : S_RY), S_ZS, S_TMP);
        nxt   = C_CD;
      end
      C_CD: begin
        cmd_c   = mk(OP_CAPD, fail ? S_DEN : S_ZS, S_ZS, S_TMP);
        publish = 1'b1;
        nxt     = C_IDLE;
      end
      default: nxt = C_IDLE;
    endcase
  end

  assign adv = (cmd_c.op == OP_NONE) || (pend && st.done);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= C_IDLE;
      pend      <= 1'b0;
      cmd_valid <= 1'b0;
      out_valid <= 1'b0;
      p_inf     <= 1'b0;
      r_inf     <= 1'b1;
      fail      <= 1'b0;
      dbl       <= 1'b0;
      kind      <= KIND_INF;
    end else begin
      cmd_valid <= 1'b0;
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (start) begin
        p_inf <= in_inf;
        r_inf <= 1'b1;
        fail  <= 1'b0;
      end
      if (adv) begin
        pend  <= 1'b0;
        state <= nxt;
        if (set_dinf) begin
          if (dbl) p_inf <= 1'b1;
          else r_inf <= 1'b1;
        end
        if (clr_dinf) begin
          if (dbl) p_inf <= 1'b0;
          else r_inf <= 1'b0;
        end
        if (set_fail) fail <= 1'b1;
        if (set_dbl) dbl <= 1'b1;
        if (clr_dbl) dbl <= 1'b0;
        if (publish) begin
          out_valid <= 1'b1;
          kind      <= fail ? KIND_FAIL : (r_inf ? KIND_INF : KIND_AFFINE);
        end
      end else if (!pend) begin
        cmd       <= cmd_c;
        cmd_valid <= 1'b1;
        pend      <= 1'b1;
      end
    end
  end

  `ECSM_ASSERT_IMPL(a_done_only_when_pending, clk, rst, st.done, pend)
  `ECSM_ASSERT_NEXT(a_cmd_single_pulse, clk, rst, cmd_valid, !cmd_valid)
  `ECSM_ASSERT_IMPL(a_capture_into_free_output, clk, rst, (state == C_CX), !out_valid)
endmodule

// ===== hw/rtl/ec_scalar_multiply_mod_top.sv =====
// The block loads and reduces the inputs, then per scalar bit adds the point if the bit is set
// and doubles it while higher bits remain, and then publishes; each add and doubling inverts by
// extended Euclid, and an operand at infinity makes an operation short.
// Throughput: one word at a time; the bit-serial multiplier and divider share one datapath.
// A new input word is taken while a finished result still waits on the output.
// Reset clears the controller, sets modulus to 3 and curve_a to 0; the register file is not
// cleared, since every slot is written before it is read.
module ec_scalar_multiply_mod_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // Fields from bit 0: scalar, point_x, point_y.
  input  logic [3*ecsm_pkg::W-1:0]       s_tdata,
  // Fields from bit 0: point_infinity.
  input  logic                           s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // Fields from bit 0: result_x, result_y, failing_denominator.
  output logic [3*ecsm_pkg::W-1:0]       m_tdata,
  // Fields from bit 0: status.
  output logic [1:0]                     m_tuser,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ecsm_pkg::IDX_W-1:0]     cfg_index,
  input  logic [ecsm_pkg::W-1:0]         cfg_data
);
  import ecsm_pkg::*;

  logic [W-1:0] modulus, curve_a, mod_eff;
  logic [W-1:0] res_x, res_y, res_den;
  logic         start, cmd_valid;
  cmd_t         cmd;
  dp_status_t   st;
  kind_t        kind;

  assign cfg_ready = 1'b1;
  assign start     = s_tvalid && s_tready;
  assign mod_eff   = (modulus < W'(3)) ? W'(3) : modulus;
  assign m_tdata   = {res_den, res_y, res_x};
  assign m_tuser   = kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= W'(3);
      curve_a <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MODULUS: modulus <= cfg_data;
        REG_CURVE_A: curve_a <= cfg_data;
        default: ;
      endcase
    end
  end

  ecsm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .in_inf    (s_tuser),
    .idle      (s_tready),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .kind      (kind),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .st        (st)
  );

  ecsm_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .in_scalar (s_tdata[W-1:0]),
    .in_x      (s_tdata[2*W-1:W]),
    .in_y      (s_tdata[3*W-1:2*W]),
    .mod_eff   (mod_eff),
    .curve_a   (curve_a),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .st        (st),
    .res_x     (res_x),
    .res_y     (res_y),
    .res_den   (res_den)
  );
endmodule
